FILE: src/cctc_pkg.sv
// ----------------------------------------------------------------------------
// cctc_pkg
// shared types and constants of the cycle-count time converter
// ----------------------------------------------------------------------------
`default_nettype none

package cctc_pkg;

    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
    localparam logic [31:0] RATE_RESET = 32'd500000000;

    // register index of the configuration port
    localparam logic REG_TICK_RATE = 1'b0;

    // conversion direction
    localparam logic ACT_TICKS_TO_NS = 1'b0;
    localparam logic ACT_NS_TO_TICKS = 1'b1;

    typedef struct packed {
        logic        action;
        logic [62:0] time_value;
    } t_in_item;

    typedef struct packed {
        logic [63:0] converted_value;
        logic        overflow;
    } t_out_item;

endpackage

`default_nettype wire

FILE: src/cctc_if.sv
// ----------------------------------------------------------------------------
// cctc_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface cctc_in_if;
    logic               valid;
    logic               ready;
    cctc_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cctc_out_if;
    logic                valid;
    logic                ready;
    cctc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/cycle_count_time_converter.sv
// ----------------------------------------------------------------------------
// cycle_count_time_converter
// ticks <-> nanoseconds conversion with a configurable counter rate
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the pipeline advances as one, so a held
//   result stalls every stage, and a stage only moves while the output is free
// the depth comes mostly from the two radix-2 divider chains, one quotient bit a stage
// reset clears all valid bits and loads tick_rate with 500000000
`default_nettype none

module cycle_count_time_converter #(
    parameter int TIME_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cctc_in_if.sink          i_in,
    cctc_out_if.source       o_out,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready
);

    // value width: only the low TIME_WIDTH-1 input bits take part
    localparam int VW = TIME_WIDTH - 1;
    // first divider: one stage per dividend bit
    localparam int D1 = VW;
    // second divider: dividend is a 64-bit product
    localparam int D2 = 64;
    localparam logic [63:0] MASK  = 64'({TIME_WIDTH{1'b1}});
    localparam logic [63:0] LIMIT = MASK >> 1;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [31:0] r_rate;
    logic        cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata = (i_paddr[2] == cctc_pkg::REG_TICK_RATE) ? r_rate : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= cctc_pkg::RATE_RESET;
        end else if (cfg_wr && i_paddr[2] == cctc_pkg::REG_TICK_RATE) begin
            r_rate <= i_pwdata;
        end
    end

    // ------------------------------------------------------------------
    // one restoring division step: returns {quotient bit, new remainder}
    // ------------------------------------------------------------------
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                             input logic [31:0] dvs);
        logic [32:0] t;
        logic        q;
        t = {rem, nb};
        q = 1'b0;
        if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
            q = 1'b1;
        end
        return {q, t[31:0]};
    endfunction

    // whole pipeline moves together while the output is free or drained
    logic en;
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // ------------------------------------------------------------------
    // stage group a: value / divisor -> whole seconds and remainder
    // t2n divides by the rate and scales by 1e9, n2t the other way round
    // ------------------------------------------------------------------
    logic          r_a_v   [0:D1];
    logic          r_a_zr  [0:D1];
    logic [31:0]   r_a_rem [0:D1];
    logic [VW-1:0] r_a_num [0:D1];
    logic [31:0]   r_a_div [0:D1];
    logic [31:0]   r_a_mul [0:D1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v[0] <= 1'b0;
        end else if (en) begin
            r_a_v[0] <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rem[0] <= 32'd0;
            r_a_num[0] <= i_in.data.time_value[VW-1:0];
            if (i_in.data.action == cctc_pkg::ACT_TICKS_TO_NS) begin
                r_a_div[0] <= r_rate;
                r_a_mul[0] <= cctc_pkg::NS_PER_SEC;
                r_a_zr[0]  <= (r_rate == 32'd0);
            end else begin
                r_a_div[0] <= cctc_pkg::NS_PER_SEC;
                r_a_mul[0] <= r_rate;
                r_a_zr[0]  <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < D1; g++) begin : g_div1
        logic [32:0] st;
        assign st = div_step(r_a_rem[g], r_a_num[g][VW-1], r_a_div[g]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_v[g+1] <= 1'b0;
            end else if (en) begin
                r_a_v[g+1] <= r_a_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_rem[g+1] <= st[31:0];
                r_a_num[g+1] <= {r_a_num[g][VW-2:0], st[32]};
                r_a_div[g+1] <= r_a_div[g];
                r_a_mul[g+1] <= r_a_mul[g];
                r_a_zr[g+1]  <= r_a_zr[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage group b: remainder * scale, then divide by the divisor again
    // index 0 is the multiplier stage
    // ------------------------------------------------------------------
    logic          r_b_v   [0:D2];
    logic          r_b_zr  [0:D2];
    logic [31:0]   r_b_rem [0:D2];
    logic [63:0]   r_b_num [0:D2];
    logic [31:0]   r_b_div [0:D2];
    logic [31:0]   r_b_mul [0:D2];
    logic [VW-1:0] r_b_sec [0:D2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v[0] <= 1'b0;
        end else if (en) begin
            r_b_v[0] <= r_a_v[D1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_rem[0] <= 32'd0;
            r_b_num[0] <= r_a_rem[D1] * r_a_mul[D1];
            r_b_div[0] <= r_a_div[D1];
            r_b_mul[0] <= r_a_mul[D1];
            r_b_zr[0]  <= r_a_zr[D1];
            r_b_sec[0] <= r_a_num[D1];
        end
    end

    for (genvar g = 0; g < D2; g++) begin : g_div2
        logic [32:0] st;
        assign st = div_step(r_b_rem[g], r_b_num[g][63], r_b_div[g]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_v[g+1] <= 1'b0;
            end else if (en) begin
                r_b_v[g+1] <= r_b_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_b_rem[g+1] <= st[31:0];
                r_b_num[g+1] <= {r_b_num[g][62:0], st[32]};
                r_b_div[g+1] <= r_b_div[g];
                r_b_mul[g+1] <= r_b_mul[g];
                r_b_zr[g+1]  <= r_b_zr[g];
                r_b_sec[g+1] <= r_b_sec[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage c: seconds * scale as two 32-bit partial products
    // ------------------------------------------------------------------
    logic        r_c_v;
    logic        r_c_zr;
    logic [63:0] r_c_p0;
    logic [63:0] r_c_p1;
    logic [31:0] r_c_frac;
    logic [63:0] sec64;

    assign sec64 = 64'(r_b_sec[D2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= r_b_v[D2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_p0   <= sec64[31:0] * r_b_mul[D2];
            r_c_p1   <= sec64[63:32] * r_b_mul[D2];
            r_c_frac <= r_b_num[D2][31:0];
            r_c_zr   <= r_b_zr[D2];
        end
    end

    // ------------------------------------------------------------------
    // output stage: final sum, truncation and overflow flag
    // ------------------------------------------------------------------
    logic        r_o_v;
    logic [63:0] r_o_val;
    logic        r_o_ovf;
    logic [95:0] sum;

    assign sum = {32'd0, r_c_p0} + {r_c_p1, 32'd0} + 96'(r_c_frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_c_zr) begin
                // zero rate, ticks to ns: no meaningful quotient
                r_o_val <= MASK;
                r_o_ovf <= 1'b1;
            end else begin
                r_o_val <= 64'(sum[TIME_WIDTH-1:0]);
                r_o_ovf <= (sum > 96'(LIMIT));
            end
        end
    end

    assign o_out.valid                = r_o_v;
    assign o_out.data.converted_value = r_o_val;
    assign o_out.data.overflow        = r_o_ovf;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_in_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_a_v[0])
        else $error("accepted item did not enter the pipeline");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_c_v) && $stable(r_b_v[D2]) && $stable(r_a_v[D1])))
        else $error("pipeline moved during a stall");

    a_sec_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v[D1] && !r_a_zr[D1]) |-> (r_a_rem[D1] < r_a_div[D1]))
        else $error("first divider remainder not below divisor");

    a_frac_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v[D2] && !r_b_zr[D2]) |-> (r_b_num[D2] < 64'(r_b_mul[D2])
                                         || r_b_mul[D2] == 32'd0))
        else $error("fraction not below scale");

    a_zero_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_c_v && r_c_zr) |=> (o_out.valid && o_out.data.overflow))
        else $error("zero rate result lost its flag");

endmodule

`default_nettype wire

FILE: tb/cycle_count_time_converter_tb.sv
// ----------------------------------------------------------------------------
// cycle_count_time_converter_tb
// checks timestamp conversion against a behavioral predictor, over several
// tick rates and idling patterns on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_count_time_converter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 131;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    cctc_in_if  in_ch();
    cctc_out_if out_ch();

    cycle_count_time_converter #(.TIME_WIDTH(64)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata),
        .o_pready(o_pready)
    );

    // predictor copy of the rate register
    logic [31:0]         rate_model;
    cctc_pkg::t_out_item pending_conv[$];
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

    // exact conversion, widened to 128 bits so nothing is lost
    function automatic cctc_pkg::t_out_item convert_time(logic act, logic [62:0] tv,
                                                         logic [31:0] rate);
        cctc_pkg::t_out_item r;
        logic [127:0] full;
        logic [63:0]  sec;
        logic [63:0]  rem;
        logic [63:0]  frac;
        if (act == cctc_pkg::ACT_TICKS_TO_NS) begin
            if (rate == 0) begin
                r.converted_value = '1;
                r.overflow = 1'b1;
                return r;
            end
            sec  = {1'b0, tv} / rate;
            rem  = {1'b0, tv} - sec * rate;
            frac = rem * cctc_pkg::NS_PER_SEC / rate;
            full = 128'(sec) * cctc_pkg::NS_PER_SEC + frac;
        end else begin
            sec  = {1'b0, tv} / cctc_pkg::NS_PER_SEC;
            rem  = {1'b0, tv} - sec * cctc_pkg::NS_PER_SEC;
            frac = rem * rate / cctc_pkg::NS_PER_SEC;
            full = 128'(sec) * rate + frac;
        end
        r.converted_value = full[63:0];
        r.overflow = (full[127:64] != 0) || full[63];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_count++;
    endtask

    // result checker; ready changes at falling edge, sampling at rising
    initial begin
        cctc_pkg::t_out_item want;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_conv.size() == 0) begin
                    report_mismatch("unexpected transfer", out_ch.data.converted_value,
                                    64'd0);
                end else begin
                    want = pending_conv.pop_front();
                    if (out_ch.data.converted_value !== want.converted_value)
                        report_mismatch("converted_value", out_ch.data.converted_value,
                                        want.converted_value);
                    if (out_ch.data.overflow !== want.overflow)
                        report_mismatch("overflow", 64'(out_ch.data.overflow),
                                        64'(want.overflow));
                end
            end
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one input transfer, with optional idle cycles first
    task automatic send_item(logic act, logic [62:0] tv);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = '{action: act, time_value: tv};
        do @(posedge i_clk); while (!in_ch.ready);
        pending_conv.push_back(convert_time(act, tv, rate_model));
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_conv.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    // apb write, only while idle
    task automatic write_rate(logic [31:0] val);
        i_psel <= 1'b1; i_pwrite <= 1'b1; i_paddr <= 3'(cctc_pkg::REG_TICK_RATE) * 3'd4;
        i_pwdata <= val; i_penable <= 1'b0;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        rate_model = val;
        @(negedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
    endtask

    function automatic logic [62:0] rand_time();
        logic [62:0] v;
        v = 63'({$urandom, $urandom});
        case ($urandom_range(3))
            0: v = v >> $urandom_range(62);
            1: v = v & 63'hFFFF_FFFF;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [62:0] edges[6];
        edges = '{63'd0, 63'd1, '1, 63'd999999999, 63'd1000000000, 63'h4000_0000_0000_0000};
        foreach (edges[k]) begin
            send_item(cctc_pkg::ACT_TICKS_TO_NS, edges[k]);
            send_item(cctc_pkg::ACT_NS_TO_TICKS, edges[k]);
        end
        drain();
    endtask

    task automatic test_rate_extremes();
        logic [31:0] rates[4];
        rates = '{32'd0, 32'd1, 32'hFFFF_FFFF, cctc_pkg::NS_PER_SEC};
        foreach (rates[k]) begin
            write_rate(rates[k]);
            send_item(cctc_pkg::ACT_TICKS_TO_NS, '1);
            send_item(cctc_pkg::ACT_NS_TO_TICKS, '1);
            send_item(cctc_pkg::ACT_TICKS_TO_NS, rand_time());
            drain();
        end
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        write_rate(($urandom_range(9) == 0) ? 32'($urandom_range(3)) : $urandom);
        repeat (count) send_item(1'($urandom), rand_time());
        // hold off until every result is back
        while (pending_conv.size() != 0) @(negedge i_clk);
        repeat (count / 4) send_item(1'($urandom), rand_time());
        drain();
    endtask

    initial begin
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rate_model = cctc_pkg::RATE_RESET;
        i_rst_n = 1'b0;
        i_psel = 1'b0; i_penable = 1'b0; i_pwrite = 1'b0; i_paddr = '0; i_pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_rate_extremes();
        for (int p = 0; p < 2; p++) begin
            test_random_phase(0, 0, 135);
            test_random_phase(62, 0, 135);
            test_random_phase(0, 62, 135);
            test_random_phase(31, 31, 135);
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

`default_nettype wire

FILE: files.f
src/cctc_pkg.sv
src/cctc_if.sv
src/cycle_count_time_converter.sv
tb/cycle_count_time_converter_tb.sv
